// File: hw/rtl/lfoc_pkg.sv
// lfoc_pkg: shared types, register codes and the pattern table of the line follow commander
// no dependencies
package lfoc_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned THR_W   = 13;
    localparam int unsigned SCORE_W = 3;
    localparam int unsigned PAT_W   = 8;
    localparam int unsigned RANGE_W = 14;
    localparam int unsigned CODE_W  = 8;

    localparam logic [CODE_W-1:0]   CMD_OBSTACLE = 8'd99;
    localparam logic [CODE_W-1:0]   CMD_NONE     = 8'd0;
    localparam logic [RANGE_W-1:0]  RANGE_NOT_READY = 14'h3FFE;

    localparam logic [THR_W-1:0]   NEAR_THR_RST = 13'd300;
    localparam logic [SCORE_W-1:0] STEP_RST     = 3'd2;
    localparam logic [SCORE_W-1:0] CAP_RST      = 3'd6;
    localparam logic [SCORE_W-1:0] CONFIRM_RST  = 3'd2;

    typedef enum logic [1:0] {
        REG_NEAR_THR = 2'd0,
        REG_STEP_UP  = 2'd1,
        REG_CAP      = 2'd2,
        REG_CONFIRM  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]   near_threshold_mm;
        logic [SCORE_W-1:0] score_step_up;
        logic [SCORE_W-1:0] score_cap;
        logic [SCORE_W-1:0] confirm_level;
    } cfg_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               obstacle;
    } score_t;

    // command for a sensor pattern, CMD_NONE when unlisted
    function automatic logic [CODE_W-1:0] pattern_code(input logic [PAT_W-1:0] p);
        logic [CODE_W-1:0] c;
        case (p)
            8'h07, 8'h03, 8'h01: c = 8'd91;
            8'h0F: c = 8'd92;
            8'h1F: c = 8'd93;
            8'hE0, 8'hC0, 8'h80: c = 8'd81;
            8'hF0: c = 8'd82;
            8'hF8: c = 8'd83;
            8'hE7: c = 8'd31;
            8'hEF: c = 8'd32;
            8'hF7: c = 8'd33;
            8'hF3: c = 8'd41;
            8'hFB: c = 8'd42;
            8'hF9: c = 8'd43;
            8'hFD: c = 8'd51;
            8'hFC: c = 8'd52;
            8'hFE: c = 8'd53;
            8'hCF: c = 8'd61;
            8'hDF: c = 8'd62;
            8'h9F: c = 8'd63;
            8'hBF: c = 8'd71;
            8'h3F: c = 8'd72;
            8'h7F: c = 8'd73;
            8'hFF: c = 8'd2;
            8'h00: c = 8'd1;
            default: c = CMD_NONE;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/lfoc_score.sv
// lfoc_score: leaky-bucket obstacle confidence score and confirmed flag
// depends on lfoc_pkg
module lfoc_score (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                upd,
    input  logic signed [lfoc_pkg::RANGE_W-1:0] range_mm,
    input  lfoc_pkg::cfg_t                      cfg,
    output lfoc_pkg::score_t                    st_next
);
    import lfoc_pkg::*;

    logic [SCORE_W-1:0] score_reg, score_next;
    logic               flag_reg, flag_next;
    logic               ready_rd;
    logic               sighting;
    logic [SCORE_W:0]   sum;

    assign ready_rd = (range_mm != RANGE_NOT_READY);
    assign sighting = !range_mm[RANGE_W-1] && (range_mm != '0)
                      && (range_mm[THR_W-1:0] <= cfg.near_threshold_mm);
    assign sum      = {1'b0, score_reg} + {1'b0, cfg.score_step_up};

    always_comb begin
        score_next = score_reg;
        flag_next  = flag_reg;
        if (ready_rd) begin
            if (sighting) begin
                score_next = (sum > {1'b0, cfg.score_cap}) ? cfg.score_cap
                                                          : sum[SCORE_W-1:0];
            end else if (score_reg != '0) begin
                score_next = score_reg - 1'b1;
            end
            if (score_next >= cfg.confirm_level) begin
                flag_next = 1'b1;
            end else if (score_next == '0) begin
                flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            score_reg <= '0;
            flag_reg  <= 1'b0;
        end else if (upd) begin
            score_reg <= score_next;
            flag_reg  <= flag_next;
        end
    end

    assign st_next.score    = score_next;
    assign st_next.obstacle = flag_next;

endmodule

// File: hw/rtl/line_follow_obstacle_commander.sv
// line_follow_obstacle_commander: top level, config registers, command logic, output skid
// depends on lfoc_pkg and lfoc_score
//
//  channel  | ports                               | dir
//  ---------+-------------------------------------+-----
//  sample   | s_valid s_ready s_line_pattern s_range_mm | in
//  command  | m_valid m_ready m_command_code      | out
//  config   | psel penable pwrite paddr pwdata prdata pready | apb
//
// one beat per cycle while s_ready is high; each command is registered before m_valid rises
// score update and table lookup sit in the cycle of acceptance, ahead of the output register
// a second output slot keeps s_ready high for one stalled command
// synchronous active-low reset clears score, flag and valids and sets config registers to defaults
module line_follow_obstacle_commander (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lfoc_pkg::PAT_W-1:0]          s_line_pattern,
    input  logic signed [lfoc_pkg::RANGE_W-1:0] s_range_mm,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lfoc_pkg::CODE_W-1:0]         m_command_code,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lfoc_pkg::ADDR_W-1:0]         paddr,
    input  logic [lfoc_pkg::DATA_W-1:0]         pwdata,
    output logic [lfoc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import lfoc_pkg::*;

    cfg_t              cfg_reg;
    reg_idx_t          reg_idx;
    score_t            st_next;
    logic              in_acc;
    logic              res_valid;
    logic [CODE_W-1:0] tbl_code;
    logic [CODE_W-1:0] res_code;

    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [CODE_W-1:0] skid_code_reg, skid_code_next;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_threshold_mm <= NEAR_THR_RST;
            cfg_reg.score_step_up     <= STEP_RST;
            cfg_reg.score_cap         <= CAP_RST;
            cfg_reg.confirm_level     <= CONFIRM_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_NEAR_THR: cfg_reg.near_threshold_mm <= pwdata[THR_W-1:0];
                REG_STEP_UP:  cfg_reg.score_step_up     <= pwdata[SCORE_W-1:0];
                REG_CAP:      cfg_reg.score_cap         <= pwdata[SCORE_W-1:0];
                REG_CONFIRM:  cfg_reg.confirm_level     <= pwdata[SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NEAR_THR: prdata = {{(DATA_W-THR_W){1'b0}}, cfg_reg.near_threshold_mm};
            REG_STEP_UP:  prdata = {{(DATA_W-SCORE_W){1'b0}}, cfg_reg.score_step_up};
            REG_CAP:      prdata = {{(DATA_W-SCORE_W){1'b0}}, cfg_reg.score_cap};
            REG_CONFIRM:  prdata = {{(DATA_W-SCORE_W){1'b0}}, cfg_reg.confirm_level};
            default:      prdata = '0;
        endcase
    end

    assign s_ready = !skid_valid_reg;
    assign in_acc  = s_valid && s_ready;

    lfoc_score u_score (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .upd      (in_acc),
        .range_mm (s_range_mm),
        .cfg      (cfg_reg),
        .st_next  (st_next)
    );

    assign tbl_code  = pattern_code(s_line_pattern);
    assign res_code  = st_next.obstacle ? CMD_OBSTACLE : tbl_code;
    assign res_valid = in_acc && (st_next.obstacle || (tbl_code != CMD_NONE));

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        skid_valid_next = skid_valid_reg;
        skid_code_next  = skid_code_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_code_next   = skid_code_reg;
                skid_valid_next = res_valid;
                skid_code_next  = res_code;
            end else begin
                out_valid_next = res_valid;
                out_code_next  = res_code;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_code_next  = res_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_code_reg  <= out_code_next;
        skid_code_reg <= skid_code_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_command_code = out_code_reg;

endmodule

// File: hw/rtl/lfoc_checker.sv
// lfoc_checker: port-level assertions for line_follow_obstacle_commander, with its bind
// depends on lfoc_pkg
module lfoc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [lfoc_pkg::CODE_W-1:0] m_command_code,
    input logic                        pready
);
    import lfoc_pkg::*;

    // a stalled command beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_command_code))
        else $error("command beat changed while stalled");

    // a command only follows an accepted sample
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("command without a sample beat");

    // input stalls only while a command is waiting
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && $past(m_valid && !m_ready))
        else $error("sample stalled with no pending command");

    // command codes are nonzero and no greater than CMD_OBSTACLE
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_command_code != CMD_NONE) && (m_command_code <= CMD_OBSTACLE))
        else $error("command code out of range");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind line_follow_obstacle_commander lfoc_checker u_lfoc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_command_code (m_command_code),
    .pready         (pready)
);

// File: tb/sv/tb_line_follow_obstacle_commander.sv
// tb_line_follow_obstacle_commander: self-checking bench for the line follow obstacle commander
// drives sensor beats and apb register writes, predicts every command byte and checks each one
// depends on lfoc_pkg and line_follow_obstacle_commander
module tb_line_follow_obstacle_commander;
    timeunit 1ns;
    timeprecision 1ps;

    import lfoc_pkg::*;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_AT         = 300;
    localparam int HOLD_CYCLES     = 80;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam logic signed [RANGE_W-1:0] RANGE_ERROR   = -14'sd1;
    localparam logic signed [RANGE_W-1:0] RANGE_INVALID = 14'sd0;
    localparam logic signed [RANGE_W-1:0] RANGE_MAX     = 14'sd8191;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;
    typedef enum logic [1:0] {EXP_PREDICT, EXP_CODE, EXP_NONE} exp_kind_t;
    typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PERIODIC} stall_mode_t;

    typedef struct packed {
        row_kind_t           kind;
        reg_idx_t            idx;
        logic [DATA_W-1:0]   value;
        logic [PAT_W-1:0]    pat;
        logic [RANGE_W-1:0]  rng;
        exp_kind_t           ek;
        logic [CODE_W-1:0]   code;
    } stim_row_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [PAT_W-1:0]           s_line_pattern;
    logic signed [RANGE_W-1:0]  s_range_mm;
    logic                       m_valid;
    logic                       m_ready;
    logic [CODE_W-1:0]          m_command_code;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    cfg_t               cfg_shadow;
    logic [SCORE_W-1:0] conf_score;
    logic               obstacle_seen;
    logic [CODE_W-1:0]  pending_commands[$];
    logic [CODE_W-1:0]  want_code;
    int                 errors;
    int                 samples_accepted;
    int                 burst_left;

    line_follow_obstacle_commander u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_line_pattern (s_line_pattern),
        .s_range_mm     (s_range_mm),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_command_code (m_command_code),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [CODE_W-1:0] table_code(input logic [PAT_W-1:0] pat);
        case (pat)
            8'h07, 8'h03, 8'h01: return 8'd91;
            8'h0F:               return 8'd92;
            8'h1F:               return 8'd93;
            8'hE0, 8'hC0, 8'h80: return 8'd81;
            8'hF0:               return 8'd82;
            8'hF8:               return 8'd83;
            8'hE7:               return 8'd31;
            8'hEF:               return 8'd32;
            8'hF7:               return 8'd33;
            8'hF3:               return 8'd41;
            8'hFB:               return 8'd42;
            8'hF9:               return 8'd43;
            8'hFD:               return 8'd51;
            8'hFC:               return 8'd52;
            8'hFE:               return 8'd53;
            8'hCF:               return 8'd61;
            8'hDF:               return 8'd62;
            8'h9F:               return 8'd63;
            8'hBF:               return 8'd71;
            8'h3F:               return 8'd72;
            8'h7F:               return 8'd73;
            8'hFF:               return 8'd2;
            8'h00:               return 8'd1;
            default:             return CMD_NONE;
        endcase
    endfunction

    // advances the score and flag for one beat, returns whether a command comes out
    function automatic bit predict_command(input logic [PAT_W-1:0] pat,
                                           input logic signed [RANGE_W-1:0] rng,
                                           output logic [CODE_W-1:0] cmd);
        logic [SCORE_W:0] raised;
        if (rng != RANGE_NOT_READY) begin
            if (rng > 0 && rng <= $signed({1'b0, cfg_shadow.near_threshold_mm})) begin
                raised = {1'b0, conf_score} + {1'b0, cfg_shadow.score_step_up};
                if (raised > {1'b0, cfg_shadow.score_cap})
                    conf_score = cfg_shadow.score_cap;
                else
                    conf_score = raised[SCORE_W-1:0];
            end else if (conf_score != '0) begin
                conf_score = conf_score - 1'b1;
            end
            if (conf_score >= cfg_shadow.confirm_level)
                obstacle_seen = 1'b1;
            else if (conf_score == '0)
                obstacle_seen = 1'b0;
        end
        cmd = obstacle_seen ? CMD_OBSTACLE : table_code(pat);
        return cmd != CMD_NONE;
    endfunction

    function automatic stim_row_t sample_row(input logic [PAT_W-1:0] pat,
                                             input logic [RANGE_W-1:0] rng,
                                             input exp_kind_t ek,
                                             input logic [CODE_W-1:0] code);
        stim_row_t r;
        r = '0;
        r.kind = ROW_SAMPLE;
        r.pat  = pat;
        r.rng  = rng;
        r.ek   = ek;
        r.code = code;
        return r;
    endfunction

    function automatic stim_row_t write_row(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        stim_row_t r;
        r = '0;
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.value = value;
        r.ek    = EXP_NONE;
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_sample(input logic [PAT_W-1:0] pat, input logic signed [RANGE_W-1:0] rng,
                               input exp_kind_t ek, input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] cmd;
        bit                has_cmd;
        int                gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_line_pattern <= pat;
        s_range_mm     <= rng;
        do @(posedge aclk); while (!s_ready);
        samples_accepted++;
        has_cmd = predict_command(pat, rng, cmd);
        case (ek)
            EXP_CODE:    pending_commands.push_back(code);
            EXP_PREDICT: if (has_cmd) pending_commands.push_back(cmd);
            default:     ;
        endcase
        @(negedge aclk);
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        wait (pending_commands.size() == 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_NEAR_THR: cfg_shadow.near_threshold_mm = value[THR_W-1:0];
            REG_STEP_UP:  cfg_shadow.score_step_up     = value[SCORE_W-1:0];
            REG_CAP:      cfg_shadow.score_cap         = value[SCORE_W-1:0];
            REG_CONFIRM:  cfg_shadow.confirm_level     = value[SCORE_W-1:0];
            default:      ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_commands.size() == 0) begin
                $display("%0t: command beat with none pending, expected nothing, got %0d",
                         $time, m_command_code);
                errors++;
            end else begin
                want_code = pending_commands.pop_front();
                if (m_command_code !== want_code) begin
                    $display("%0t: command mismatch, expected %0d, got %0d",
                             $time, want_code, m_command_code);
                    errors++;
                end
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_line_follow_obstacle_commander failed");
        $finish;
    end

    // receiver stall patterns, plus one long hold so the input backs up
    initial begin
        stall_mode_t mode;
        int          len;
        bit          held;
        m_ready = 1'b0;
        held    = 1'b0;
        wait (aresetn);
        forever begin
            mode = stall_mode_t'($urandom_range(0, 3));
            len  = $urandom_range(8, 120);
            for (int k = 0; k < len; k++) begin
                @(negedge aclk);
                if (!held && samples_accepted >= HOLD_AT) begin
                    held = 1'b1;
                    m_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                end
                case (mode)
                    READY_ALWAYS:   m_ready <= 1'b1;
                    READY_HALF:     m_ready <= ($urandom_range(0, 1) == 1);
                    READY_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                    default:        m_ready <= k[2];
                endcase
            end
        end
    end

    initial begin
        stim_row_t                 rows[$];
        logic [PAT_W-1:0]          pat;
        logic signed [RANGE_W-1:0] rng;
        int                        thr;
        int                        run_left;
        int                        sight_pct;
        int                        new_thr, new_step, new_cap, new_conf;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_line_pattern = '0;
        s_range_mm     = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        errors           = 0;
        samples_accepted = 0;
        burst_left       = 0;
        run_left         = 0;
        sight_pct        = 50;
        cfg_shadow.near_threshold_mm = NEAR_THR_RST;
        cfg_shadow.score_step_up     = STEP_RST;
        cfg_shadow.score_cap         = CAP_RST;
        cfg_shadow.confirm_level     = CONFIRM_RST;
        conf_score    = '0;
        obstacle_seen = 1'b0;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: not ready, far, error on an unlisted pattern, zero range, first sighting
        rows.push_back(sample_row(8'h00, RANGE_NOT_READY, EXP_CODE, 8'd1));
        rows.push_back(sample_row(8'hFF, RANGE_MAX, EXP_CODE, 8'd2));
        rows.push_back(sample_row(8'h55, RANGE_ERROR, EXP_NONE, CMD_NONE));
        rows.push_back(sample_row(8'hE7, RANGE_INVALID, EXP_CODE, 8'd31));
        rows.push_back(sample_row(8'h07, 14'sd1, EXP_CODE, CMD_OBSTACLE));
        // obstacle overrides an unlisted pattern, then the score leaks back to zero
        rows.push_back(sample_row(8'h55, RANGE_NOT_READY, EXP_PREDICT, CMD_NONE));
        rows.push_back(sample_row(8'h0F, 14'sd300, EXP_PREDICT, CMD_NONE));
        rows.push_back(sample_row(8'h1F, 14'sd301, EXP_PREDICT, CMD_NONE));
        rows.push_back(sample_row(8'h03, RANGE_ERROR, EXP_PREDICT, CMD_NONE));
        rows.push_back(sample_row(8'hE0, 14'sd5000, EXP_PREDICT, CMD_NONE));
        rows.push_back(sample_row(8'hF0, RANGE_MAX, EXP_PREDICT, CMD_NONE));
        // fill to the cap, then lower the cap under the score
        rows.push_back(sample_row(8'hF8, 14'sd10, EXP_PREDICT, CMD_NONE));
        rows.push_back(sample_row(8'hF8, 14'sd10, EXP_PREDICT, CMD_NONE));
        rows.push_back(sample_row(8'hF8, 14'sd10, EXP_PREDICT, CMD_NONE));
        rows.push_back(write_row(REG_CAP, 32'd1));
        rows.push_back(sample_row(8'hEF, 14'sd10, EXP_PREDICT, CMD_NONE));
        rows.push_back(sample_row(8'hF7, RANGE_MAX, EXP_PREDICT, CMD_NONE));
        // zero step with the widest threshold
        rows.push_back(write_row(REG_NEAR_THR, 32'd8191));
        rows.push_back(write_row(REG_STEP_UP, 32'd0));
        rows.push_back(write_row(REG_CAP, 32'd7));
        rows.push_back(write_row(REG_CONFIRM, 32'd7));
        rows.push_back(sample_row(8'hF3, RANGE_MAX, EXP_PREDICT, CMD_NONE));
        // confirm level of zero
        rows.push_back(write_row(REG_CONFIRM, 32'd0));
        rows.push_back(write_row(REG_STEP_UP, 32'd7));
        rows.push_back(sample_row(8'hFB, RANGE_NOT_READY, EXP_PREDICT, CMD_NONE));
        rows.push_back(sample_row(8'hF9, RANGE_INVALID, EXP_PREDICT, CMD_NONE));
        rows.push_back(sample_row(8'hFD, 14'sd1, EXP_PREDICT, CMD_NONE));
        // zero threshold, nothing counts as a sighting
        rows.push_back(write_row(REG_NEAR_THR, 32'd0));
        rows.push_back(sample_row(8'hFC, 14'sd1, EXP_PREDICT, CMD_NONE));
        rows.push_back(sample_row(8'hAA, 14'sd1, EXP_PREDICT, CMD_NONE));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_WRITE) begin
                settle_idle();
                write_register(rows[i].idx, rows[i].value);
            end else begin
                send_sample(rows[i].pat, rows[i].rng, rows[i].ek, rows[i].code);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    new_thr = 8191; new_step = 7; new_cap = 7; new_conf = 7;
                end
                1: begin
                    new_thr = 0; new_step = 0; new_cap = 0; new_conf = 1;
                end
                default: begin
                    new_thr  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                           : $urandom_range(20, 600);
                    new_step = $urandom_range(0, 7);
                    new_cap  = $urandom_range(0, 7);
                    new_conf = $urandom_range(1, 7);
                end
            endcase
            settle_idle();
            write_register(REG_NEAR_THR, new_thr);
            write_register(REG_STEP_UP, new_step);
            write_register(REG_CAP, new_cap);
            write_register(REG_CONFIRM, new_conf);
            thr = int'(cfg_shadow.near_threshold_mm);

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // runs of approaching, clearing and mixed readings
                if (run_left == 0) begin
                    run_left = $urandom_range(4, 30);
                    case ($urandom_range(0, 2))
                        0:       sight_pct = 85;
                        1:       sight_pct = 10;
                        default: sight_pct = 50;
                    endcase
                end
                run_left--;

                if ($urandom_range(0, 9) < 7) begin
                    do pat = PAT_W'($urandom_range(0, 255)); while (table_code(pat) == CMD_NONE);
                end else begin
                    pat = PAT_W'($urandom_range(0, 255));
                end

                if ($urandom_range(0, 99) < 12) begin
                    case ($urandom_range(0, 5))
                        0:       rng = RANGE_NOT_READY;
                        1:       rng = RANGE_ERROR;
                        2:       rng = RANGE_INVALID;
                        3:       rng = RANGE_MAX;
                        4:       rng = RANGE_W'(thr);
                        default: rng = RANGE_W'((thr < 8191) ? thr + 1 : 8191);
                    endcase
                end else if ($urandom_range(0, 99) < sight_pct && thr > 0) begin
                    rng = RANGE_W'($urandom_range(1, thr));
                end else if (thr < 8191) begin
                    rng = RANGE_W'($urandom_range(thr + 1, 8191));
                end else begin
                    rng = RANGE_ERROR;
                end

                send_sample(pat, rng, EXP_PREDICT, CMD_NONE);
            end
        end

        settle_idle();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("tb_line_follow_obstacle_commander passed");
        else
            $display("tb_line_follow_obstacle_commander failed");
        $finish;
    end

endmodule
